// ===== rtl/ftqg_pkg.sv =====
// ----------------------------------------------------------------------------
// ftqg_pkg
// Shared constants, types and register codes of the frame time governor.
// ----------------------------------------------------------------------------
package ftqg_pkg;

  localparam int WINDOW     = 60;
  localparam int DWELL      = 60;
  localparam int NUM_LEVELS = 5;

  localparam int FT_W    = 16;
  localparam int LVL_W   = 3;
  localparam int TOTAL_W = 22;
  localparam int FILLO_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SUM_W   = $clog2(WINDOW * 65535 + 1);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int DWELL_W = $clog2(DWELL + 1);
  localparam int TF_W    = FT_W + FILL_W;
  localparam int CMP_W   = ((SUM_W > TF_W) ? SUM_W : TF_W) + 7;

  localparam logic [FT_W-1:0]  RST_TARGET = 16'd4267;
  localparam int               RST_START  = 2;
  localparam logic [LVL_W-1:0] LVL_MAX    = LVL_W'(NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_RST    =
    LVL_W'((RST_START > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : RST_START);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADAPT_ENABLE = 2'd0,
    CFG_TARGET_TIME  = 2'd1,
    CFG_START_LEVEL  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic [TF_W-1:0]   tf;
  } win_stat_t;

  typedef struct packed {
    logic             load;
    logic [LVL_W-1:0] value;
  } lvl_wr_t;

endpackage

// ===== rtl/frame_time_quality_governor_unit.sv =====
// ----------------------------------------------------------------------------
// frame_time_quality_governor_unit
// Moving-average quality governor with hysteresis over a frame-time window.
// ----------------------------------------------------------------------------
// One frame time is taken per clock while the result side does not stall, and
// one result follows per frame. The first stage shifts the value into the
// history chain, updates the running sum and fill count, and forms the
// target-times-fill product; the second runs the two threshold compares and
// updates the dwell count and level. A stall on the result side holds both
// stages and backs up onto the input. No clearing pass is needed after reset.
module frame_time_quality_governor_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ftqg_pkg::FT_W-1:0]        in_frame_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ftqg_pkg::LVL_W-1:0]       out_level,
  output logic                             out_lowered,
  output logic                             out_raised,
  output logic [ftqg_pkg::TOTAL_W-1:0]     out_window_total,
  output logic [ftqg_pkg::FILLO_W-1:0]     out_window_fill,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ftqg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ftqg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ftqg_pkg::*;

  logic            s1_v_r;
  logic            s1_v_nxt;
  logic            out_v_r;
  logic            out_v_nxt;
  logic            out_free;
  logic            take;
  logic            accept;
  logic            cfg_wr;
  logic            adapt_r;
  logic            adapt_nxt;
  logic [FT_W-1:0] target_r;
  logic [FT_W-1:0] target_nxt;
  win_stat_t       stat;
  lvl_wr_t         lvl_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    adapt_nxt    = adapt_r;
    target_nxt   = target_r;
    lvl_wr.load  = 1'b0;
    lvl_wr.value = LVL_W'(cfg_data);
    if (cfg_wr) begin
      case (cfg_index)
        CFG_ADAPT_ENABLE: adapt_nxt   = cfg_data[0];
        CFG_TARGET_TIME:  target_nxt  = cfg_data;
        CFG_START_LEVEL:  lvl_wr.load = 1'b1;
        default:          ;
      endcase
    end
  end

  always_comb begin
    out_free  = !out_v_r || !out_stall;
    take      = s1_v_r && out_free;
    in_stall  = s1_v_r && !out_free;
    accept    = in_valid && !in_stall;
    s1_v_nxt  = accept ? 1'b1 : (take ? 1'b0 : s1_v_r);
    out_v_nxt = take ? 1'b1 : (out_free ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      adapt_r  <= 1'b0;
      target_r <= RST_TARGET;
    end else begin
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
      adapt_r  <= adapt_nxt;
      target_r <= target_nxt;
    end
  end

  ftqg_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .ft_in       (in_frame_time),
    .target_time (target_r),
    .stat        (stat)
  );

  ftqg_decide u_decide (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .adapt_enable (adapt_r),
    .stat         (stat),
    .lvl_wr       (lvl_wr),
    .level        (out_level),
    .lowered      (out_lowered),
    .raised       (out_raised),
    .window_total (out_window_total),
    .window_fill  (out_window_fill)
  );

  assign out_valid = out_v_r;

`ifndef SYNTHESIS
  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_lowered && out_raised))
    else $error("lowered and raised in the same beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= FILL_W'(WINDOW))
    else $error("fill count beyond window");

  a_lower_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !lvl_wr.load |=> out_lowered ? (out_level == $past(out_level) - 1'b1) :
      (out_raised ? (out_level == $past(out_level) + 1'b1) :
      (out_level == $past(out_level))))
    else $error("level moved by more than one step");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && out_v_r)
    else $error("input stalled with a free stage");
`endif

endmodule

// ===== rtl/ftqg_cell.sv =====
// ----------------------------------------------------------------------------
// ftqg_cell
// One history cell: holds a frame time and passes it on at each new beat.
// ----------------------------------------------------------------------------
module ftqg_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [ftqg_pkg::FT_W-1:0] d,
  output logic [ftqg_pkg::FT_W-1:0] q
);
  import ftqg_pkg::*;

  logic [FT_W-1:0] val_r;
  logic [FT_W-1:0] val_nxt;

  always_comb begin
    val_nxt = shift ? d : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

// ===== rtl/ftqg_window.sv =====
// ----------------------------------------------------------------------------
// ftqg_window
// History chain, running sum, fill count and target-times-fill product.
// ----------------------------------------------------------------------------
module ftqg_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [ftqg_pkg::FT_W-1:0] ft_in,
  input  logic [ftqg_pkg::FT_W-1:0] target_time,
  output ftqg_pkg::win_stat_t       stat
);
  import ftqg_pkg::*;

  logic [FT_W-1:0]   taps [WINDOW+1];
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [TF_W-1:0]   tf_r;
  logic [TF_W-1:0]   tf_nxt;

  assign taps[0] = ft_in;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    ftqg_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (load),
      .d     (taps[i]),
      .q     (taps[i+1])
    );
  end

  always_comb begin
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    tf_nxt   = tf_r;
    if (load) begin
      sum_nxt = sum_r - SUM_W'(taps[WINDOW]) + SUM_W'(ft_in);
      if (fill_r < FILL_W'(WINDOW)) begin
        fill_nxt = fill_r + 1'b1;
      end
      tf_nxt = TF_W'(target_time) * TF_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
      tf_r   <= '0;
    end else begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
      tf_r   <= tf_nxt;
    end
  end

  assign stat.sum  = sum_r;
  assign stat.fill = fill_r;
  assign stat.tf   = tf_r;

endmodule

// ===== rtl/ftqg_decide.sv =====
// ----------------------------------------------------------------------------
// ftqg_decide
// Dwell count, threshold compares and quality level, with result registers.
// ----------------------------------------------------------------------------
module ftqg_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic                          adapt_enable,
  input  ftqg_pkg::win_stat_t           stat,
  input  ftqg_pkg::lvl_wr_t             lvl_wr,
  output logic [ftqg_pkg::LVL_W-1:0]    level,
  output logic                          lowered,
  output logic                          raised,
  output logic [ftqg_pkg::TOTAL_W-1:0]  window_total,
  output logic [ftqg_pkg::FILLO_W-1:0]  window_fill
);
  import ftqg_pkg::*;

  logic [LVL_W-1:0]   level_r;
  logic [LVL_W-1:0]   level_nxt;
  logic [DWELL_W-1:0] dwell_r;
  logic [DWELL_W-1:0] dwell_nxt;
  logic               lowered_r;
  logic               lowered_nxt;
  logic               raised_r;
  logic               raised_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic [FILLO_W-1:0] fill_r;
  logic               active;
  logic               too_slow;
  logic               too_fast;
  logic [CMP_W-1:0]   sum_w;
  logic [CMP_W-1:0]   tf_w;

  always_comb begin
    sum_w    = CMP_W'(stat.sum);
    tf_w     = CMP_W'(stat.tf);
    too_slow = (sum_w * CMP_W'(100)) > (tf_w * CMP_W'(115));
    too_fast = (sum_w * CMP_W'(5)) < (tf_w * CMP_W'(4));
    active   = adapt_enable && (stat.sum != '0);

    level_nxt   = level_r;
    dwell_nxt   = dwell_r;
    lowered_nxt = lowered_r;
    raised_nxt  = raised_r;

    if (lvl_wr.load && (lvl_wr.value <= LVL_MAX)) begin
      level_nxt = lvl_wr.value;
    end

    if (take) begin
      lowered_nxt = 1'b0;
      raised_nxt  = 1'b0;
      if (active) begin
        if (dwell_r < DWELL_W'(DWELL)) begin
          dwell_nxt = dwell_r + 1'b1;
        end
        if (dwell_nxt >= DWELL_W'(DWELL)) begin
          if (too_slow) begin
            if (level_r != '0) begin
              level_nxt   = level_r - 1'b1;
              dwell_nxt   = '0;
              lowered_nxt = 1'b1;
            end
          end else if (too_fast) begin
            if (level_r < LVL_MAX) begin
              level_nxt  = level_r + 1'b1;
              dwell_nxt  = '0;
              raised_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LVL_RST;
      dwell_r   <= '0;
      lowered_r <= 1'b0;
      raised_r  <= 1'b0;
    end else begin
      level_r   <= level_nxt;
      dwell_r   <= dwell_nxt;
      lowered_r <= lowered_nxt;
      raised_r  <= raised_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      total_r <= TOTAL_W'(stat.sum);
      fill_r  <= FILLO_W'(stat.fill);
    end
  end

  assign level        = level_r;
  assign lowered      = lowered_r;
  assign raised       = raised_r;
  assign window_total = total_r;
  assign window_fill  = fill_r;

endmodule
